// File: rtl/triangle_unit_normal_macros.svh
// Assertion helpers used by rtl/triangle_unit_normal.sv.
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// Checks that a property holds at every edge outside reset.
`define TUN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that one condition implies another in the next cycle.
`define TUN_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: rtl/tun_pkg.sv
`timescale 1ns / 1ps
package tun_pkg;

  localparam int unsigned CW = 24;
  localparam int unsigned NW = 16;
  // Edge, product, cross and magnitude widths.
  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned XW = PW + 1;
  localparam int unsigned MW = 31;
  localparam int unsigned SW = 64;
  localparam int unsigned LW = 32;
  localparam int unsigned BLW = 7;
  // Square root cells (one result bit each) and divider cells (one quotient bit each).
  localparam int unsigned SQ_STEPS = LW;
  localparam int unsigned QW = NW + 1;
  localparam int unsigned DV_STEPS = QW;
  localparam int unsigned NUMW = MW + NW + 1;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic                 ok;
  } tri_out_t;

  // Data carried by every cell of the square root chain.
  typedef struct packed {
    logic [SW-1:0]    rem;
    logic [SW-1:0]    root;
    logic [2:0][MW-1:0] m;
    logic [2:0]       neg;
    logic             ok;
  } sq_t;

  // Data carried by every cell of the divider chain.
  typedef struct packed {
    logic [2:0][NUMW-1:0] num;
    logic [2:0][QW-1:0]   q;
    logic [LW-1:0]        len;
    logic [2:0]           neg;
    logic                 ok;
  } dv_t;

endpackage

// File: rtl/tun_sqrt_cell.sv
`timescale 1ns / 1ps
module tun_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  tun_pkg::sq_t  dat_i,
  output logic          vld_o,
  output tun_pkg::sq_t  dat_o
);
  import tun_pkg::*;

  localparam logic [SW-1:0] Bit = SW'(1) << (SW - 2 - 2 * Step);

  sq_t  dat_d, dat_q;
  logic vld_q;
  logic [SW-1:0] trial;

  // One digit-by-digit restoring step of the integer square root.
  always_comb begin
    dat_d = dat_i;
    trial = dat_i.root + Bit;
    if (dat_i.rem >= trial) begin
      dat_d.rem  = dat_i.rem - trial;
      dat_d.root = (dat_i.root >> 1) + Bit;
    end else begin
      dat_d.root = dat_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule

// File: rtl/tun_div_cell.sv
`timescale 1ns / 1ps
module tun_div_cell #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  tun_pkg::dv_t  dat_i,
  output logic          vld_o,
  output tun_pkg::dv_t  dat_o
);
  import tun_pkg::*;

  localparam int unsigned Sh = DV_STEPS - 1 - Step;

  dv_t  dat_d, dat_q;
  logic vld_q;
  logic [NUMW+QW-1:0] dsh;

  // One restoring division step for each of the three components.
  always_comb begin
    dat_d = dat_i;
    dsh   = (NUMW + QW)'(dat_i.len) << Sh;
    for (int i = 0; i < 3; i++) begin
      if ((NUMW + QW)'(dat_i.num[i]) >= dsh) begin
        dat_d.num[i] = NUMW'((NUMW + QW)'(dat_i.num[i]) - dsh);
        dat_d.q[i]   = dat_i.q[i] | (QW'(1) << Sh);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule

// File: rtl/triangle_unit_normal.sv
// Unit face normal of a triangle, fully pipelined.
// Data passes through the front stages, the square root cells, the divider cells and the output register.
// Throughput: one triangle per cycle; the whole pipe stalls only when the
// output register is full and not taken. The square root and divider chains set the depth.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module triangle_unit_normal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tun_pkg::tri_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::tri_out_t  out_data_o
);
  import tun_pkg::*;
  `include "triangle_unit_normal_macros.svh"

  // Global advance: the pipe moves when the output register can take data.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: edges.
  logic v1_q;
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EW'(in_data_i.ax) - EW'(in_data_i.bx);
      e1_q[1] <= EW'(in_data_i.ay) - EW'(in_data_i.by);
      e1_q[2] <= EW'(in_data_i.az) - EW'(in_data_i.bz);
      e2_q[0] <= EW'(in_data_i.cx) - EW'(in_data_i.bx);
      e2_q[1] <= EW'(in_data_i.cy) - EW'(in_data_i.by);
      e2_q[2] <= EW'(in_data_i.cz) - EW'(in_data_i.bz);
    end
  end

  // Stage 2: six products (25 x 25 bits each).
  logic v2_q;
  logic signed [PW-1:0] pa_q [3], pb_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= e2_q[1] * e1_q[2];
      pb_q[0] <= e2_q[2] * e1_q[1];
      pa_q[1] <= e2_q[2] * e1_q[0];
      pb_q[1] <= e2_q[0] * e1_q[2];
      pa_q[2] <= e2_q[0] * e1_q[1];
      pb_q[2] <= e2_q[1] * e1_q[0];
    end
  end

  // Stage 3: cross components as magnitude and sign.
  logic v3_q;
  logic [XW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  logic signed [XW-1:0] cr [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = XW'(pa_q[i]) - XW'(pb_q[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= cr[i][XW-1];
        mag3_q[i] <= cr[i][XW-1] ? XW'(-cr[i]) : XW'(cr[i]);
      end
    end
  end

  // Stage 4: bit length of the OR of magnitudes (priority encode).
  logic v4_q;
  logic [XW-1:0] mag4_q [3];
  logic [2:0]    neg4_q;
  logic [BLW-1:0] bl4_q;
  logic [XW-1:0] orall;
  logic [BLW-1:0] bl;
  always_comb begin
    orall = mag3_q[0] | mag3_q[1] | mag3_q[2];
    bl    = '0;
    for (int b = 0; b < XW; b++) begin
      if (orall[b]) bl = BLW'(b + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      bl4_q  <= bl;
    end
  end

  // Stage 5: normalise to [2^30, 2^31).
  logic v5_q, ok5_q;
  logic [MW-1:0] m5_q [3];
  logic [2:0]    neg5_q;
  logic [MW-1:0] msc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl4_q <= BLW'(MW)) begin
        msc[i] = MW'(mag4_q[i] << (BLW'(MW) - bl4_q));
      end else begin
        msc[i] = MW'(mag4_q[i] >> (bl4_q - BLW'(MW)));
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_q   <= msc;
      neg5_q <= neg4_q;
      ok5_q  <= (bl4_q != '0);
    end
  end

  // Stage 6: sum of squares (three 31 x 31 products summed).
  logic v6_q;
  sq_t  sq_in;
  logic [SW-1:0] ssum;
  always_comb begin
    ssum = SW'(m5_q[0]) * SW'(m5_q[0]) + SW'(m5_q[1]) * SW'(m5_q[1])
         + SW'(m5_q[2]) * SW'(m5_q[2]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_in.rem  <= ssum;
      sq_in.root <= '0;
      sq_in.m    <= {m5_q[2], m5_q[1], m5_q[0]};
      sq_in.neg  <= neg5_q;
      sq_in.ok   <= ok5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  // Square root chain.
  logic sq_v [SQ_STEPS+1];
  sq_t  sq_d [SQ_STEPS+1];
  assign sq_v[0] = v6_q;
  assign sq_d[0] = sq_in;
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    tun_sqrt_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(sq_v[g]), .dat_i(sq_d[g]),
      .vld_o(sq_v[g+1]), .dat_o(sq_d[g+1])
    );
  end

  // Divider chain input: numerator m * 2^(NW-1) + floor(L/2).
  dv_t dv_in;
  logic [LW-1:0] len;
  always_comb begin
    len = LW'(sq_d[SQ_STEPS].root);
    dv_in.len = len;
    dv_in.neg = sq_d[SQ_STEPS].neg;
    dv_in.ok  = sq_d[SQ_STEPS].ok;
    for (int i = 0; i < 3; i++) begin
      dv_in.num[i] = (NUMW'(sq_d[SQ_STEPS].m[i]) << (NW - 1)) + NUMW'(len >> 1);
      dv_in.q[i]   = '0;
    end
  end

  logic dv_v [DV_STEPS+1];
  dv_t  dv_d [DV_STEPS+1];
  assign dv_v[0] = sq_v[SQ_STEPS];
  assign dv_d[0] = dv_in;
  for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
    tun_div_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(dv_v[g]), .dat_i(dv_d[g]),
      .vld_o(dv_v[g+1]), .dat_o(dv_d[g+1])
    );
  end

  // Output register: saturate, apply sign, zero on degenerate.
  localparam logic [QW-1:0] QMax = QW'((1 << (NW - 1)) - 1);
  tri_out_t res_d, res_q;
  logic     ovld_q;
  logic [NW-1:0] qs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = (dv_d[DV_STEPS].q[i] > QMax) ? NW'(QMax) : NW'(dv_d[DV_STEPS].q[i]);
      if (!dv_d[DV_STEPS].ok) qs[i] = '0;
      else if (dv_d[DV_STEPS].neg[i]) qs[i] = NW'(-qs[i]);
    end
    res_d.nx = qs[0];
    res_d.ny = qs[1];
    res_d.nz = qs[2];
    res_d.ok = dv_d[DV_STEPS].ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (en) begin
      ovld_q <= dv_v[DV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

  `TUN_ASSERT(a_ready_follows_out, in_ready_o == (!out_valid_o || out_ready_i), "ready mismatch")
  `TUN_ASSERT_NEXT(a_hold_on_stall, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output changed while stalled")
  `TUN_ASSERT(a_degenerate_zero, !out_valid_o || out_data_o.ok || (out_data_o.nx == '0 && out_data_o.ny == '0 && out_data_o.nz == '0), "degenerate normal not zero")
endmodule
